// ===== rtl/psr_pkg.sv =====
package psr_pkg;

    // Frame geometry.
    localparam int FRAME_ROWS = 32;
    localparam int FRAME_COLS = 32;

    // Counter widths follow the frame geometry.
    localparam int ROW_CNT_W = $clog2(FRAME_ROWS);
    localparam int COL_CNT_W = $clog2(FRAME_COLS);

    // Port widths.
    localparam int LEVEL_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int ROW_INDEX_W = 10;
    localparam int COL_INDEX_W = 6;

    localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(FRAME_ROWS - 1);
    localparam logic [COL_CNT_W-1:0] LAST_COL = COL_CNT_W'(FRAME_COLS - 1);

    localparam logic [LEVEL_W-1:0] MAX_LEVEL    = 4'd9;
    localparam logic [LEVEL_W-1:0] THRESH_RESET = 4'd1;

    // Controller states.
    typedef enum logic [0:0] {
        ST_STREAM,
        ST_FLUSH
    } psr_state_t;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic                 shift;
        logic                 emit;
        logic                 upper_ok;
        logic                 below_ok;
        logic                 left_ok;
        logic                 right_ok;
        logic                 corner;
        logic                 run_last;
        logic                 frame_end;
        logic [ROW_CNT_W-1:0] row;
        logic [COL_CNT_W-1:0] col;
    } psr_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic out_free;
    } psr_status_t;

    // Palette lookup: " .':~*= %#" indexed by level.
    function automatic logic [CHAR_W-1:0] level_to_char(input logic [LEVEL_W-1:0] lvl);
        logic [CHAR_W-1:0] ch;
        unique case (lvl)
            4'd0:    ch = 8'h20;
            4'd1:    ch = 8'h2E;
            4'd2:    ch = 8'h27;
            4'd3:    ch = 8'h3A;
            4'd4:    ch = 8'h7E;
            4'd5:    ch = 8'h2A;
            4'd6:    ch = 8'h3D;
            4'd7:    ch = 8'h20;
            4'd8:    ch = 8'h25;
            default: ch = 8'h23;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/pixel_spike_removal_ascii.sv =====
// Output: a pixel's word leaves one row later, registered as the input below it is accepted;
// the last row leaves during a flush after the final input.
// Throughput: one pixel per cycle while the output is not stalled; once per frame the input
// stalls while a flush walks the last row, one pixel at a time, through the output register.
// Reset: counters return to the top-left pixel and the threshold to 1; line contents
// are not cleared, since every entry is written in a frame before it is read.
module pixel_spike_removal_ascii
    import psr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LEVEL_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [LEVEL_W-1:0]     pixel_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAR_W-1:0]      char_code,
    output logic [LEVEL_W-1:0]     corrected_level,
    output logic [ROW_INDEX_W-1:0] row_index,
    output logic [COL_INDEX_W-1:0] col_index,
    output logic                   frame_end,
    output logic                   run_last
);

    psr_cmd_t    cmd;
    psr_status_t status;

    // Sequencer for raster position and last-row flush.
    psr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Line delays, spike correction and output register.
    psr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .pixel_level     (pixel_level),
        .cmd             (cmd),
        .status          (status),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .char_code       (char_code),
        .corrected_level (corrected_level),
        .row_index       (row_index),
        .col_index       (col_index),
        .frame_end       (frame_end),
        .run_last        (run_last)
    );

endmodule

// ===== rtl/psr_ctrl.sv =====
module psr_ctrl
    import psr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  psr_status_t status,
    output psr_cmd_t    cmd
);

    psr_state_t           state_reg, state_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;
    logic [COL_CNT_W-1:0] col_reg, col_next;
    logic                 in_fire;
    logic                 flush_step;
    logic                 last_in_frame;

    // A flush cycle only runs when the output register can take its word.
    assign flush_step    = (state_reg == ST_FLUSH) && status.out_free;
    assign last_in_frame = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    // Handshake and command outputs.
    always_comb
    begin
        in_stall = (state_reg == ST_FLUSH) || !status.out_free;
        in_fire  = in_valid && !in_stall;
        cmd      = '0;
        cmd.col  = col_reg;
        unique case (state_reg)
            ST_STREAM:
            begin
                cmd.shift     = in_fire;
                cmd.emit      = in_fire && (row_reg != '0);
                cmd.row       = row_reg - 1'b1;
                cmd.below_ok  = 1'b1;
                cmd.run_last  = !last_in_frame;
                cmd.frame_end = 1'b0;
            end
            ST_FLUSH:
            begin
                cmd.shift     = flush_step;
                cmd.emit      = flush_step;
                cmd.row       = LAST_ROW;
                cmd.below_ok  = 1'b0;
                cmd.run_last  = (col_reg == LAST_COL);
                cmd.frame_end = (col_reg == LAST_COL);
            end
            default:
            begin
                cmd.shift = 1'b0;
            end
        endcase
        cmd.upper_ok = (cmd.row != '0);
        cmd.left_ok  = (col_reg != '0);
        cmd.right_ok = (col_reg != LAST_COL);
        cmd.corner   = ((cmd.row == '0) || (cmd.row == LAST_ROW))
                       && ((col_reg == '0) || (col_reg == LAST_COL));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_STREAM:
            begin
                if (in_fire && last_in_frame)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_step && (col_reg == LAST_COL))
                begin
                    state_next = ST_STREAM;
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
    end

    // Position counters: row and column of the next input, column of the flush.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (in_fire || flush_step)
        begin
            if (col_reg == LAST_COL)
            begin
                col_next = '0;
                if (in_fire)
                begin
                    row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STREAM;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // The row counter sits at zero for the whole flush.
    a_flush_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (row_reg == '0))
        else $error("row counter not cleared during flush");

    // No word is produced unless the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("word produced while output register is blocked");

    // The final pixel of a frame always starts the flush.
    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_in_frame) |=> (state_reg == ST_FLUSH) && (col_reg == '0))
        else $error("flush did not start after the final pixel");

endmodule

// ===== rtl/psr_dp.sv =====
module psr_dp
    import psr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LEVEL_W-1:0]     cfg_wr_data,
    input  logic [LEVEL_W-1:0]     pixel_level,
    input  psr_cmd_t               cmd,
    output psr_status_t            status,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [CHAR_W-1:0]      char_code,
    output logic [LEVEL_W-1:0]     corrected_level,
    output logic [ROW_INDEX_W-1:0] row_index,
    output logic [COL_INDEX_W-1:0] col_index,
    output logic                   frame_end,
    output logic                   run_last
);

    // 43/256 slightly exceeds 1/6 and gives exact floor(x/6) for x below 64.
    localparam logic [12:0] RECIP_SIX = 13'd43;

    logic [LEVEL_W-1:0] thresh_reg;
    logic [LEVEL_W-1:0] raw_line_reg  [FRAME_COLS];
    logic [LEVEL_W-1:0] corr_line_reg [FRAME_COLS];

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [ROW_CNT_W-1:0]   row_reg;
    logic [COL_CNT_W-1:0]   col_reg;
    logic                   frame_end_reg;
    logic                   run_last_reg;

    logic [LEVEL_W-1:0] lvl_sat;
    logic [LEVEL_W-1:0] self_lvl, upper_lvl, below_lvl, left_lvl, right_lvl;
    logic               spike;
    logic [5:0]         nb_sum;
    logic [6:0]         avg4_num;
    logic [6:0]         avg3_num;
    logic [12:0]        avg3_prod;
    logic [LEVEL_W-1:0] avg_lvl;
    logic [LEVEL_W-1:0] corr_lvl;

    function automatic logic [LEVEL_W-1:0] abs_diff(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Input saturation and neighborhood taps.
    assign lvl_sat   = (pixel_level > MAX_LEVEL) ? MAX_LEVEL : pixel_level;
    assign self_lvl  = raw_line_reg[FRAME_COLS-1];
    assign right_lvl = raw_line_reg[FRAME_COLS-2];
    assign upper_lvl = corr_line_reg[FRAME_COLS-1];
    assign left_lvl  = corr_line_reg[0];
    assign below_lvl = lvl_sat;

    // Spike test and rounded neighbor average.
    always_comb
    begin
        spike = !cmd.corner
                && (!cmd.upper_ok || (abs_diff(self_lvl, upper_lvl) > thresh_reg))
                && (!cmd.below_ok || (abs_diff(self_lvl, below_lvl) > thresh_reg))
                && (!cmd.left_ok  || (abs_diff(self_lvl, left_lvl)  > thresh_reg))
                && (!cmd.right_ok || (abs_diff(self_lvl, right_lvl) > thresh_reg));
        nb_sum = (cmd.upper_ok ? 6'(upper_lvl) : 6'd0)
                 + (cmd.below_ok ? 6'(below_lvl) : 6'd0)
                 + (cmd.left_ok  ? 6'(left_lvl)  : 6'd0)
                 + (cmd.right_ok ? 6'(right_lvl) : 6'd0);
        // Four neighbors: (s + 2) / 4. Three neighbors: (2s + 3) / 6.
        avg4_num  = 7'(nb_sum) + 7'd2;
        avg3_num  = {nb_sum, 1'b0} + 7'd3;
        avg3_prod = 13'(avg3_num) * RECIP_SIX;
        if (cmd.upper_ok && cmd.below_ok && cmd.left_ok && cmd.right_ok)
        begin
            avg_lvl = avg4_num[5:2];
        end
        else
        begin
            avg_lvl = avg3_prod[11:8];
        end
        corr_lvl = spike ? avg_lvl : self_lvl;
    end

    // Output register handshake.
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid_next  = cmd.emit || (out_valid_reg && out_stall);

    // Threshold register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Raw line delay, corrected line delay and output word.
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            raw_line_reg[0] <= lvl_sat;
            for (int k = 1; k < FRAME_COLS; k++)
            begin
                raw_line_reg[k] <= raw_line_reg[k-1];
            end
        end
        if (cmd.emit)
        begin
            corr_line_reg[0] <= corr_lvl;
            for (int k = 1; k < FRAME_COLS; k++)
            begin
                corr_line_reg[k] <= corr_line_reg[k-1];
            end
            char_reg      <= level_to_char(corr_lvl);
            level_reg     <= corr_lvl;
            row_reg       <= cmd.row;
            col_reg       <= cmd.col;
            frame_end_reg <= cmd.frame_end;
            run_last_reg  <= cmd.run_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign char_code       = char_reg;
    assign corrected_level = level_reg;
    assign row_index       = ROW_INDEX_W'(row_reg);
    assign col_index       = COL_INDEX_W'(col_reg);
    assign frame_end       = frame_end_reg;
    assign run_last        = run_last_reg;

    // Corrected levels never leave the palette range.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg <= MAX_LEVEL))
        else $error("corrected level out of range");

    // The frame's last word also closes its run.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> run_last_reg)
        else $error("frame end without run end");

    // Character and level in the output word agree.
    a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == level_to_char(level_reg)))
        else $error("palette character does not match level");

endmodule
